// ===== sv/trpe_pkg.sv =====
// ----------------------------------------------------------------------------
// trpe_pkg - shared types and constants for the preview extractor
// Word layouts, outcome codes, record tags and signature bytes.
// ----------------------------------------------------------------------------
package trpe_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       stream_end;
    } trpe_item_t;

    typedef struct packed {
        logic [7:0] preview_byte;
        logic       byte_valid;
        logic       finished;
        logic [2:0] outcome;
        logic [1:0] image_kind;
    } trpe_result_t;

    localparam logic [2:0] OC_NONE    = 3'd0;
    localparam logic [2:0] OC_OK      = 3'd1;
    localparam logic [2:0] OC_BADSIG  = 3'd2;
    localparam logic [2:0] OC_NOPREV  = 3'd3;
    localparam logic [2:0] OC_BADSIZE = 3'd4;
    localparam logic [2:0] OC_TRUNC   = 3'd5;
    localparam logic [2:0] OC_CAP     = 3'd6;

    localparam logic [31:0] TAG_EOF  = 32'd3;
    localparam logic [31:0] TAG_COMP = 32'd30;
    localparam logic [31:0] TAG_GIF  = 32'd61;
    localparam logic [31:0] TAG_JPEG = 32'd62;
    localparam logic [31:0] TAG_PNG  = 32'd63;

    localparam logic [0:0] CFG_MAX_PREVIEW = 1'b0;
    localparam logic [0:0] CFG_MAX_RECORDS = 1'b1;

    localparam logic [31:0] MAX_PREVIEW_RESET = 32'h0400_0000;
    localparam logic [7:0]  MAX_RECORDS_RESET = 8'd64;

    // file signature, byte by position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h58;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h52;
            3'd3:    b = 8'h41;
            3'd4:    b = 8'hA3;
            3'd5:    b = 8'hA3;
            3'd6:    b = 8'h0D;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/trpe_parser.sv =====
// ----------------------------------------------------------------------------
// trpe_parser - per-byte record parser
// Holds the parse state; decides the result for one word in a single pass.
// ----------------------------------------------------------------------------
module trpe_parser
    import trpe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  trpe_item_t   item,
    input  logic [31:0]  max_preview_size,
    input  logic [7:0]   max_records,
    output logic         res_valid,
    output trpe_result_t res
);

    localparam logic [1:0] PH_SIG  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  fbc_reg, fbc_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  rec_reg, rec_next;
    logic [1:0]  kind_reg, kind_next;
    logic        done_reg, done_next;

    logic [31:0] tag, size;
    logic [7:0]  cap;
    logic        skipped;

    assign cap = (max_records == 8'd0) ? 8'd1 : max_records;

    always_comb begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        hdr_next   = hdr_reg;
        rem_next   = rem_reg;
        rec_next   = rec_reg;
        kind_next  = kind_reg;
        done_next  = done_reg;
        tag        = '0;
        size       = '0;
        skipped    = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        if (item.file_start) begin
            phase_next = PH_SIG;
            fbc_next   = '0;
            rec_next   = '0;
            kind_next  = '0;
            done_next  = 1'b0;
        end

        if (item.stream_end) begin
            if (!done_next) begin
                res_valid    = 1'b1;
                res.finished = 1'b1;
                res.outcome  = OC_TRUNC;
            end
        end else if (!done_next) begin
            unique case (phase_next)
                PH_SIG: begin
                    if (item.data_byte != sig_byte(fbc_next)) begin
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.outcome  = OC_BADSIG;
                    end else if (fbc_next == 3'd7) begin
                        phase_next = PH_HDR;
                        fbc_next   = '0;
                    end else begin
                        fbc_next = fbc_next + 3'd1;
                    end
                end
                PH_HDR: begin
                    hdr_next = {item.data_byte, hdr_next[63:8]};
                    if (fbc_next == 3'd7) begin
                        fbc_next = '0;
                        tag      = hdr_next[31:0];
                        size     = hdr_next[63:32];
                        if (rec_next != 8'hFF)
                            rec_next = rec_next + 8'd1;
                        if (tag == TAG_GIF || tag == TAG_JPEG || tag == TAG_PNG) begin
                            kind_next = 2'(tag - TAG_GIF);
                            if (size == 32'd0 || size > max_preview_size) begin
                                res_valid    = 1'b1;
                                res.finished = 1'b1;
                                res.outcome  = OC_BADSIZE;
                            end else begin
                                rem_next   = size;
                                phase_next = PH_BODY;
                            end
                        end else if (tag == TAG_EOF || tag == TAG_COMP) begin
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                            res.outcome  = OC_NOPREV;
                        end else begin
                            rem_next = size;
                            if (size == 32'd0)
                                skipped = 1'b1;
                            else
                                phase_next = PH_SKIP;
                        end
                    end else begin
                        fbc_next = fbc_next + 3'd1;
                    end
                end
                PH_SKIP: begin
                    if (rem_next != 32'd0)
                        rem_next = rem_next - 32'd1;
                    if (rem_next == 32'd0)
                        skipped = 1'b1;
                end
                default: begin
                    if (rem_next != 32'd0)
                        rem_next = rem_next - 32'd1;
                    res_valid        = 1'b1;
                    res.preview_byte = item.data_byte;
                    res.byte_valid   = 1'b1;
                    if (rem_next == 32'd0) begin
                        res.finished = 1'b1;
                        res.outcome  = OC_OK;
                    end
                end
            endcase

            // end of a skipped record body: next header or give up
            if (skipped) begin
                if (rec_next >= cap) begin
                    res_valid    = 1'b1;
                    res.finished = 1'b1;
                    res.outcome  = OC_CAP;
                end else begin
                    phase_next = PH_HDR;
                    fbc_next   = '0;
                end
            end
        end

        res.image_kind = kind_next;
        if (res_valid && res.finished)
            done_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG;
            fbc_reg   <= '0;
            rec_reg   <= '0;
            kind_reg  <= '0;
            done_reg  <= 1'b0;
        end else if (en) begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            rec_reg   <= rec_next;
            kind_reg  <= kind_next;
            done_reg  <= done_next;
        end
    end

    // header bytes are all replaced before use; counter is loaded on entry
    always_ff @(posedge aclk) begin
        if (en) begin
            hdr_reg <= hdr_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== sv/trpe_out_buf.sv =====
// ----------------------------------------------------------------------------
// trpe_out_buf - two-entry result buffer
// Output register plus skid slot between the parser and the result channel.
// ----------------------------------------------------------------------------
module trpe_out_buf
    import trpe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  trpe_result_t push_data,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_ready,
    output trpe_result_t out_data
);

    logic [1:0]   count_reg, count_next;
    trpe_result_t head_reg, head_next;
    trpe_result_t tail_reg, tail_next;
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop && !push) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (push && !pop) begin
            if (count_reg == 2'd0)
                head_next = push_data;
            else
                tail_next = push_data;
            count_next = count_reg + 2'd1;
        end else if (push && pop) begin
            if (count_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ===== sv/tagged_record_preview_extractor.sv =====
// ----------------------------------------------------------------------------
// tagged_record_preview_extractor - preview image extractor
// Checks the file signature, walks tag/size records and streams out the body
// of the first GIF, JPEG or PNG preview record, ending with an outcome code.
//
//   channel | dir | tdata                       | tuser                      | tlast
//   s_      | in  | [7:0] data_byte             | [0] file_start [1] stream_end | -
//   m_      | out | [7:0] preview_byte [10:8] outcome | [0] byte_valid [2:1] image_kind | finished
//   cfg_    | in  | reg 0 max_preview_size, reg 1 max_records (write only)
//
// One word per cycle sustained while the result buffer has room: an input register,
// the parse logic, then a two-entry result buffer. m_tvalid follows once a result
// is registered in the buffer. The parse step stalls only when both result slots are full.
// aresetn (synchronous) clears parse state, empties the buffers and loads both registers' reset values.
// ----------------------------------------------------------------------------
module tagged_record_preview_extractor
    import trpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] file_start, [1] stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] preview_byte, [10:8] outcome, rest 0
    output logic [2:0]  m_tuser,   // [0] byte_valid, [2:1] image_kind
    output logic        m_tlast,   // finished
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0]  max_preview_reg;
    logic [7:0]   max_records_reg;
    logic         in_valid_reg, in_valid_next;
    trpe_item_t   in_item_reg;
    logic         s_fire, proc_fire, has_room, res_valid;
    trpe_result_t res, out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_preview_reg <= MAX_PREVIEW_RESET;
            max_records_reg <= MAX_RECORDS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_PREVIEW: max_preview_reg <= cfg_wr_data;
                CFG_MAX_RECORDS: max_records_reg <= cfg_wr_data[7:0];
            endcase
        end
    end

    assign proc_fire     = in_valid_reg && has_room;
    assign s_tready      = !in_valid_reg || has_room;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !proc_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.data_byte  <= s_tdata;
            in_item_reg.file_start <= s_tuser[0];
            in_item_reg.stream_end <= s_tuser[1];
        end
    end

    trpe_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (proc_fire),
        .item             (in_item_reg),
        .max_preview_size (max_preview_reg),
        .max_records      (max_records_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    trpe_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (proc_fire && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {5'd0, out_res.outcome, out_res.preview_byte};
    assign m_tuser = {out_res.image_kind, out_res.byte_valid};
    assign m_tlast = out_res.finished;

endmodule

// ===== sv/trpe_checker.sv =====
// ----------------------------------------------------------------------------
// trpe_checker - port-level checks for the preview extractor
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module trpe_checker
    import trpe_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // a word without a body byte is always a final word
    a_status_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("status word not final or carries data");

    // finished exactly when an outcome is given
    a_fin_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[10:8] != OC_NONE))
        else $error("finished flag and outcome disagree");

    // body bytes finish only with ok
    a_body_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tlast |-> m_tdata[10:8] == OC_OK)
        else $error("last body byte without ok outcome");

endmodule

bind tagged_record_preview_extractor trpe_checker u_trpe_checker (.*);
